>>> rtl/qtba_pkg.sv
// Shared types, constants, the arctangent table and clamp helpers for the quaternion bend-angle block.
package qtba_pkg;

  localparam int XW = 34;          // CORDIC x/y datapath width (Q30 plus growth)
  localparam int ZW = 35;          // CORDIC angle accumulator width (Q30)
  localparam int TABLE_LEN = 24;

  localparam logic signed [ZW-1:0] PI_Q30  = 35'sd3373259426;
  localparam logic signed [ZW-1:0] ONE_Q30 = 35'sd1073741824;

  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
  } qtba_vec_t;

  // atan(2^-i) in Q30
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0:  v = 35'sh03243F6A8;
      1:  v = 35'sh01DAC6705;
      2:  v = 35'sh00FADBAFC;
      3:  v = 35'sh007F56EA6;
      4:  v = 35'sh003FEAB76;
      5:  v = 35'sh001FFD55B;
      6:  v = 35'sh000FFFAAA;
      7:  v = 35'sh0007FFF55;
      8:  v = 35'sh0003FFFEA;
      9:  v = 35'sh0001FFFFD;
      10: v = 35'sh0000FFFFF;
      11: v = 35'sh00007FFFF;
      12: v = 35'sh00003FFFF;
      13: v = 35'sh00001FFFF;
      14: v = 35'sh00000FFFF;
      15: v = 35'sh000007FFF;
      16: v = 35'sh000003FFF;
      17: v = 35'sh000001FFF;
      18: v = 35'sh000000FFF;
      19: v = 35'sh0000007FF;
      20: v = 35'sh0000003FF;
      21: v = 35'sh0000001FF;
      22: v = 35'sh0000000FF;
      23: v = 35'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a Q30 sum to [-1, 1]
  function automatic logic signed [31:0] clamp_unit(input logic signed [ZW-1:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) r = 32'sh40000000;
    else if (v < -ONE_Q30) r = -32'sh40000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [ZW-1:0] clamp_pi(input logic signed [ZW-1:0] v);
    logic signed [ZW-1:0] r;
    if (v > PI_Q30) r = PI_Q30;
    else if (v < -PI_Q30) r = -PI_Q30;
    else r = v;
    return r;
  endfunction

endpackage

>>> rtl/qtba_cordic_cell.sv
// One vectoring CORDIC iteration, registered, passed on to the next cell every cycle.
module qtba_cordic_cell #(
  parameter int IDX = 0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qtba_pkg::qtba_vec_t vec_i,
  output qtba_pkg::qtba_vec_t vec_o
);

  logic                           vld_r;
  logic signed [qtba_pkg::XW-1:0] x_r, y_r, xs, ys;
  logic signed [qtba_pkg::ZW-1:0] z_r, ang;

  assign xs  = vec_i.x >>> IDX;
  assign ys  = vec_i.y >>> IDX;
  assign ang = qtba_pkg::atan_q30(IDX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vec_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (vec_i.y >= 0) begin
      x_r <= vec_i.x + ys;
      y_r <= vec_i.y - xs;
      z_r <= vec_i.z + ang;
    end else begin
      x_r <= vec_i.x - ys;
      y_r <= vec_i.y + xs;
      z_r <= vec_i.z - ang;
    end
  end

  assign vec_o.vld = vld_r;
  assign vec_o.x   = x_r;
  assign vec_o.y   = y_r;
  assign vec_o.z   = z_r;

endmodule

>>> rtl/imu_quaternion_to_bend_angles_core.sv
// Top level: frame hold, z-axis products, integer square root and the CORDIC cell chain.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid/in_ready   | header bytes, Euler words, quaternion
//   out_    | output    | out_valid/out_ready | accept flag, held Euler, bend angle/direction
//   cfg_    | input     | cfg_we              | cfg_index, cfg_wdata (15 bits)
//
// One request runs 8 multiply steps on one shared multiplier, a 31-step square-root
// loop, then both atan2 vectors run one behind the other through the
// CORDIC_ITERATIONS-cell chain.
// Reset (synchronous, rst_n low) clears the held frame and loads register defaults.
// A finished result sits in the output register; a new request is taken meanwhile and
// its result waits in DONE until the output register is free.
module imu_quaternion_to_bend_angles_core #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int ANGLE_FRAC_BITS   = 13
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_header_first,
  input  logic [7:0]         in_header_second,
  input  logic signed [15:0] in_roll_raw,
  input  logic signed [15:0] in_pitch_raw,
  input  logic signed [15:0] in_yaw_raw,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_frame_accepted,
  output logic signed [15:0] out_roll_held,
  output logic signed [15:0] out_pitch_held,
  output logic signed [15:0] out_yaw_held,
  output logic [14:0]        out_bend_angle,
  output logic signed [15:0] out_bend_direction,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [14:0]        cfg_wdata
);

  localparam int XW = qtba_pkg::XW;
  localparam int ZW = qtba_pkg::ZW;
  localparam int AW = ZW + 1;
  localparam int SH = 30 - ANGLE_FRAC_BITS;
  localparam longint PI_OUT_L = (64'sd3373259426 + (64'sd1 <<< (SH - 1))) >>> SH;
  localparam logic signed [AW-1:0] PI_OUT = AW'(PI_OUT_L);
  localparam logic signed [AW-1:0] HALF   = AW'(64'sd1 <<< (SH - 1));
  localparam logic [7:0] HDR_FIRST  = 8'h55;
  localparam logic [7:0] HDR_SECOND = 8'h53;
  localparam logic REG_THRESHOLD = 1'b0;
  localparam logic REG_FLOOR     = 1'b1;
  localparam logic [4:0] ROOT_LAST = 5'd30;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_MUL    = 9'b000000010,
    S_CLAMP  = 9'b000000100,
    S_SQ     = 9'b000001000,
    S_ROOT   = 9'b000010000,
    S_LNCH_A = 9'b000100000,
    S_LNCH_B = 9'b001000000,
    S_WAIT   = 9'b010000000,
    S_DONE   = 9'b100000000
  } st_t;

  st_t st_r, st_nxt;

  logic [14:0] thr_r, floor_r;
  logic signed [15:0] w_r, x_r, y_r, z_r, roll_r, pitch_r, yaw_r;
  logic ok_r;
  logic [2:0] mcnt_r;
  logic [4:0] rcnt_r;
  logic signed [33:0] acc1_r, acc2_r, acc3_r;
  logic signed [31:0] n1_r, n2_r, n3_r;
  logic [61:0] rem_r, root_r, bit_r;
  logic got_a_r;
  logic signed [ZW-1:0] za_r, zb_r;
  logic yz_a_r, xn_a_r, yz_b_r, xn_b_r;

  logic accept;
  assign in_ready = (st_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= 15'd1065;
      floor_r <= 15'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: thr_r   <= cfg_wdata;
        REG_FLOOR:     floor_r <= cfg_wdata;
        default:       thr_r   <= thr_r;
      endcase
    end
  end

  // held frame
  logic hdr_ok;
  assign hdr_ok = (in_header_first == HDR_FIRST) && (in_header_second == HDR_SECOND);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0; x_r <= '0; y_r <= '0; z_r <= '0;
      roll_r <= '0; pitch_r <= '0; yaw_r <= '0;
    end else if (accept && hdr_ok) begin
      w_r <= in_quat_w; x_r <= in_quat_x; y_r <= in_quat_y; z_r <= in_quat_z;
      roll_r <= in_roll_raw; pitch_r <= in_pitch_raw; yaw_r <= in_yaw_raw;
    end
  end

  // shared multiplier, one product per cycle
  logic signed [15:0] ma, mb;
  logic signed [31:0] prod;
  logic signed [33:0] prod_x;
  always_comb begin
    case (mcnt_r)
      3'd0:    begin ma = w_r; mb = y_r; end
      3'd1:    begin ma = x_r; mb = z_r; end
      3'd2:    begin ma = y_r; mb = z_r; end
      3'd3:    begin ma = w_r; mb = x_r; end
      3'd4:    begin ma = w_r; mb = w_r; end
      3'd5:    begin ma = x_r; mb = x_r; end
      3'd6:    begin ma = y_r; mb = y_r; end
      default: begin ma = z_r; mb = z_r; end
    endcase
  end
  assign prod   = ma * mb;
  assign prod_x = 34'(prod);

  // n3 squared and square-root step
  logic [30:0] n3m;
  logic [61:0] sq, trial;
  assign n3m   = n3_r[31] ? 31'(-n3_r) : n3_r[30:0];
  assign sq    = n3m * n3m;
  assign trial = root_r + bit_r;

  // launch into the cell chain, with pi pre-rotation for negative x
  qtba_pkg::qtba_vec_t link [CORDIC_ITERATIONS+1];
  logic signed [XW-1:0] lx, ly;
  always_comb begin
    if (st_r == S_LNCH_A) begin
      lx = -(34'(n3_r));
      ly = $signed({2'b00, root_r[31:0]});
    end else begin
      lx = 34'(n1_r);
      ly = -(34'(n2_r));
    end
    link[0].vld = (st_r == S_LNCH_A) || (st_r == S_LNCH_B);
    if (lx < 0) begin
      link[0].x = -lx;
      link[0].y = -ly;
      link[0].z = (ly >= 0) ? qtba_pkg::PI_Q30 : -qtba_pkg::PI_Q30;
    end else begin
      link[0].x = lx;
      link[0].y = ly;
      link[0].z = '0;
    end
  end

  for (genvar g = 0; g < CORDIC_ITERATIONS; g++) begin : g_cell
    qtba_cordic_cell #(.IDX(g)) u_cell (
      .clk  (clk),
      .rst_n(rst_n),
      .vec_i(link[g]),
      .vec_o(link[g+1])
    );
  end

  // result assembly
  logic signed [ZW-1:0] fa, fb;
  logic signed [AW-1:0] ra, rb, a_fl, a_cl, b_fin;
  always_comb begin
    fa = yz_a_r ? (xn_a_r ? qtba_pkg::PI_Q30 : '0) : qtba_pkg::clamp_pi(za_r);
    fb = yz_b_r ? (xn_b_r ? qtba_pkg::PI_Q30 : '0) : qtba_pkg::clamp_pi(zb_r);
    ra = (AW'(fa) + HALF) >>> SH;
    rb = (AW'(fb) + HALF) >>> SH;
    a_fl = (ra < $signed({{(AW-15){1'b0}}, floor_r})) ?
           $signed({{(AW-15){1'b0}}, floor_r}) : ra;
    a_cl = (a_fl > PI_OUT) ? PI_OUT : a_fl;
    b_fin = (a_cl < $signed({{(AW-15){1'b0}}, thr_r})) ? '0 : rb;
  end

  logic out_load;
  assign out_load = (st_r == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:   if (accept) st_nxt = S_MUL;
      S_MUL:    if (mcnt_r == 3'd7) st_nxt = S_CLAMP;
      S_CLAMP:  st_nxt = S_SQ;
      S_SQ:     st_nxt = S_ROOT;
      S_ROOT:   if (rcnt_r == ROOT_LAST) st_nxt = S_LNCH_A;
      S_LNCH_A: st_nxt = S_LNCH_B;
      S_LNCH_B: st_nxt = S_WAIT;
      S_WAIT:   if (link[CORDIC_ITERATIONS].vld && got_a_r) st_nxt = S_DONE;
      S_DONE:   if (out_load) st_nxt = S_IDLE;
      default:  st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_IDLE;
      mcnt_r    <= '0;
      rcnt_r    <= '0;
      got_a_r   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_MUL) mcnt_r <= mcnt_r + 3'd1;
      else mcnt_r <= '0;
      if (st_r == S_ROOT) rcnt_r <= rcnt_r + 5'd1;
      else rcnt_r <= '0;
      if (st_r == S_WAIT && link[CORDIC_ITERATIONS].vld) got_a_r <= 1'b1;
      else if (st_r == S_DONE) got_a_r <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ok_r   <= hdr_ok;
      acc1_r <= '0;
      acc2_r <= '0;
      acc3_r <= '0;
    end
    if (st_r == S_MUL) begin
      case (mcnt_r)
        3'd0, 3'd1: acc1_r <= acc1_r + prod_x;
        3'd2:       acc2_r <= acc2_r + prod_x;
        3'd3:       acc2_r <= acc2_r - prod_x;
        3'd4, 3'd7: acc3_r <= acc3_r + prod_x;
        default:    acc3_r <= acc3_r - prod_x;
      endcase
    end
    if (st_r == S_CLAMP) begin
      n1_r <= qtba_pkg::clamp_unit($signed({acc1_r, 1'b0}));
      n2_r <= qtba_pkg::clamp_unit($signed({acc2_r, 1'b0}));
      n3_r <= qtba_pkg::clamp_unit(ZW'(acc3_r));
    end
    if (st_r == S_SQ) begin
      rem_r  <= (62'd1 << 60) - sq;
      root_r <= '0;
      bit_r  <= 62'd1 << 60;
    end
    if (st_r == S_ROOT) begin
      if (rem_r >= trial) begin
        rem_r  <= rem_r - trial;
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
    if (st_r == S_LNCH_A) begin
      yz_a_r <= (ly == 0);
      xn_a_r <= (lx < 0);
    end
    if (st_r == S_LNCH_B) begin
      yz_b_r <= (ly == 0);
      xn_b_r <= (lx < 0);
    end
    if (st_r == S_WAIT && link[CORDIC_ITERATIONS].vld) begin
      if (!got_a_r) za_r <= link[CORDIC_ITERATIONS].z;
      else zb_r <= link[CORDIC_ITERATIONS].z;
    end
    if (out_load) begin
      out_frame_accepted <= ok_r;
      out_roll_held      <= roll_r;
      out_pitch_held     <= pitch_r;
      out_yaw_held       <= yaw_r;
      out_bend_angle     <= a_cl[14:0];
      out_bend_direction <= b_fin[15:0];
    end
  end

  // chain results only arrive while the sequencer collects them
  assert property (@(posedge clk) disable iff (!rst_n)
    link[CORDIC_ITERATIONS].vld |-> st_r == S_WAIT)
    else $error("cordic chain output outside collect phase");

  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_LNCH_A |-> root_r <= (62'd1 << 30))
    else $error("square root exceeds one");

  assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE |-> (a_cl <= PI_OUT && a_cl >= 0))
    else $error("bend angle outside [0, pi]");

  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == S_DONE))
    else $error("result shown without completion");

endmodule
